@@ hdl/tpp_pkg.sv @@
package tpp_pkg;

  // Torus geometry: sectors around the main ring, rings around the tube.
  localparam int SECTORS = 200;
  localparam int RINGS = 45;

  // Quarter-wave sine table: entries 0..QSINE_LAST hold round(32767*sin(pi/2*k/1024)).
  localparam int QSINE_LAST = 1024;
  localparam int QSINE_AW = 11;
  localparam int MAG_W = 15;
  localparam real HALF_PI = 1.5707963267948966;
  localparam real QSINE_STEP = HALF_PI / 1024.0;

  // Fixed-point torus radii in Q.15: r = 350 + 150*cos(beta), z = 1000 + 150*sin(beta).
  localparam int R_W = 24;
  localparam int Z_W = 26;
  localparam int TERM_W = 23;
  localparam logic [R_W-1:0] R_BASE = 24'd11468800;
  localparam logic [Z_W-1:0] Z_BASE = 26'd32768000;
  localparam logic [7:0] TUBE_RADIUS = 8'd150;

  // Projection datapath widths.
  localparam int PROD_W = R_W + MAG_W;
  localparam int FOCAL_W = 16;
  localparam int SCALED_W = PROD_W + FOCAL_W;
  localparam int DEN_SHIFT = 19;
  localparam int NUM_W = SCALED_W - DEN_SHIFT;
  localparam int QUO_W = 12;

  // Screen limits.
  localparam int DIM_W = 13;
  localparam int PIX_W = 12;
  localparam logic [DIM_W-1:0] SCREEN_MAX = 13'd4096;

  // Pipeline stage numbering.
  localparam int ST_ANGLE = 1;
  localparam int ST_ROM = 3;
  localparam int ST_SCALE = 4;
  localparam int DIV_FIRST = 7;
  localparam int DIV_LAST = DIV_FIRST + QUO_W - 1;
  localparam int NUM_STAGES = DIV_LAST + 1;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH   = 3'd0,
    REG_SCREEN_HEIGHT  = 3'd1,
    REG_FOCAL_LENGTH   = 3'd2,
    REG_TUBE_SPIN_RATE = 3'd3,
    REG_RING_SPIN_RATE = 3'd4
  } cfg_reg_t;

  typedef logic [15:0] sector_tbl_t [0:255];
  typedef logic [15:0] ring_tbl_t [0:63];
  typedef logic [MAG_W-1:0] qsine_tbl_t [0:QSINE_LAST];
  typedef logic [NUM_W+1:0] div_wide_t;

  typedef struct packed {
    logic [QSINE_AW-1:0] idx;
    logic                neg;
  } sine_addr_t;

  typedef struct packed {
    sine_addr_t sa;
    sine_addr_t ca;
    sine_addr_t sb;
    sine_addr_t cb;
    logic [7:0] shade;
  } trig_req_t;

  typedef struct packed {
    logic [MAG_W-1:0] sa_mag;
    logic [MAG_W-1:0] ca_mag;
    logic [MAG_W-1:0] sb_mag;
    logic [MAG_W-1:0] cb_mag;
    logic             sa_neg;
    logic             ca_neg;
    logic             sb_neg;
    logic             cb_neg;
    logic [7:0]       shade;
  } trig_val_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [Z_W-1:0]   z;
    logic             neg_x;
    logic             neg_y;
    logic [7:0]       shade;
  } div_in_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem_x;
    logic [NUM_W-1:0] rem_y;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic [Z_W-1:0]   z;
    logic             neg_x;
    logic             neg_y;
    logic [7:0]       shade;
  } div_stage_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic             neg_x;
    logic             neg_y;
    logic [7:0]       shade;
  } div_out_t;

  function automatic sector_tbl_t build_sector_angle();
    sector_tbl_t tbl;
    for (int k = 0; k < 256; k++) begin
      tbl[k] = 16'((k * 65536) / SECTORS);
    end
    return tbl;
  endfunction

  function automatic ring_tbl_t build_ring_angle();
    ring_tbl_t tbl;
    for (int k = 0; k < 64; k++) begin
      tbl[k] = 16'((k * 65536) / RINGS);
    end
    return tbl;
  endfunction

  function automatic qsine_tbl_t build_quarter_sine();
    qsine_tbl_t tbl;
    real ang;
    for (int k = 0; k <= QSINE_LAST; k++) begin
      ang = real'(k) * QSINE_STEP;
      tbl[k] = MAG_W'($rtoi($floor(32767.0 * $sin(ang) + 0.5)));
    end
    return tbl;
  endfunction

  // Folds a 12-bit angle code onto the quarter-wave table.
  function automatic sine_addr_t sine_addr(input logic [11:0] k);
    sine_addr_t a;
    a.neg = k[11];
    a.idx = k[10] ? (11'd1024 - {1'b0, k[9:0]}) : {1'b0, k[9:0]};
    return a;
  endfunction

endpackage

@@ hdl/torus_point_project_unit.sv @@
// Throughput: one point per cycle while pixel_stall is low; every stage is a register,
// the longest path is one multiplier (stages one, five and six) or one 38-bit compare
// and subtract (divider stages).
// Reset (rst, synchronous) empties all stages and restores the reset register values:
// width 1024, height 768, focal length 14189, tube rate 8011, ring rate 4005.
module torus_point_project_unit
  import tpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 point_valid,
  output logic                 point_stall,
  input  logic [15:0]          frame,
  input  logic [7:0]           sector,
  input  logic [5:0]           ring,
  output logic                 pixel_valid,
  input  logic                 pixel_stall,
  output logic [PIX_W-1:0]     x_pixel,
  output logic [PIX_W-1:0]     y_pixel,
  output logic [7:0]           shade,
  output logic                 visible,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers. The user must change them only while no transaction is in
  // flight; the block itself does not enforce this. Every stage reads them directly.
  logic [DIM_W-1:0]   screen_width;
  logic [DIM_W-1:0]   screen_height;
  logic [FOCAL_W-1:0] focal_length;
  logic [15:0]        tube_spin_rate;
  logic [15:0]        ring_spin_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width   <= 13'd1024;
      screen_height  <= 13'd768;
      focal_length   <= 16'd14189;
      tube_spin_rate <= 16'd8011;
      ring_spin_rate <= 16'd4005;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:   screen_width   <= cfg_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT:  screen_height  <= cfg_data[DIM_W-1:0];
        REG_FOCAL_LENGTH:   focal_length   <= cfg_data;
        REG_TUBE_SPIN_RATE: tube_spin_rate <= cfg_data;
        REG_RING_SPIN_RATE: ring_spin_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control. Each stage carries a valid bit and loads when it is empty or
  // when the stage after it loads, so bubbles close up while the output is stalled
  // and new points keep entering until every stage holds one.
  logic [NUM_STAGES:1] v;
  logic [NUM_STAGES:1] v_in;
  logic [NUM_STAGES:1] en;

  assign v_in = {v[NUM_STAGES-1:1], point_valid};

  always_comb begin
    en[NUM_STAGES] = !v[NUM_STAGES] || !pixel_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v_in[k];
        end
      end
    end
  end

  assign point_stall = !en[1];
  assign pixel_valid = v[NUM_STAGES];

  // Stages one and two: angle codes and quarter-wave table addresses.
  trig_req_t req;

  tpp_angle u_angle (
    .clk            (clk),
    .en             (en[ST_ANGLE+1:ST_ANGLE]),
    .frame          (frame),
    .sector         (sector),
    .ring           (ring),
    .ring_spin_rate (ring_spin_rate),
    .tube_spin_rate (tube_spin_rate),
    .req            (req)
  );

  // Stage three: two dual-read table copies, one for alpha and one for beta. The
  // signs and the shade ride alongside in plain registers.
  trig_val_t val;
  logic      sa_neg3;
  logic      ca_neg3;
  logic      sb_neg3;
  logic      cb_neg3;
  logic [7:0] shade3;

  tpp_sine_rom u_rom_alpha (
    .clk    (clk),
    .en     (en[ST_ROM]),
    .addr_a (req.sa.idx),
    .addr_b (req.ca.idx),
    .data_a (val.sa_mag),
    .data_b (val.ca_mag)
  );

  tpp_sine_rom u_rom_beta (
    .clk    (clk),
    .en     (en[ST_ROM]),
    .addr_a (req.sb.idx),
    .addr_b (req.cb.idx),
    .data_a (val.sb_mag),
    .data_b (val.cb_mag)
  );

  always_ff @(posedge clk) begin
    if (en[ST_ROM]) begin
      sa_neg3 <= req.sa.neg;
      ca_neg3 <= req.ca.neg;
      sb_neg3 <= req.sb.neg;
      cb_neg3 <= req.cb.neg;
      shade3  <= req.shade;
    end
  end

  assign val.sa_neg = sa_neg3;
  assign val.ca_neg = ca_neg3;
  assign val.sb_neg = sb_neg3;
  assign val.cb_neg = cb_neg3;
  assign val.shade  = shade3;

  // Stages four to six: torus radius and depth, then the two multiplications that
  // build the magnitudes of x*focal and y*focal.
  div_in_t div_in;

  tpp_scale u_scale (
    .clk          (clk),
    .en           (en[ST_SCALE+2:ST_SCALE]),
    .val          (val),
    .focal_length (focal_length),
    .dout         (div_in)
  );

  // Stages seven to eighteen: the perspective divide, one quotient bit per stage.
  // Quotient magnitudes stay below 2410, so twelve bits cover every case.
  div_out_t div_out;

  tpp_divider u_divider (
    .clk  (clk),
    .en   (en[DIV_LAST:DIV_FIRST]),
    .din  (div_in),
    .dout (div_out)
  );

  // Final stage: center on the screen, clip and register the result. Sizes above
  // 4096 behave as 4096; a zero size makes every point invisible.
  logic [DIM_W-1:0]  w_clamp;
  logic [DIM_W-1:0]  h_clamp;
  logic signed [13:0] ox;
  logic signed [13:0] oy;
  logic signed [13:0] xp;
  logic signed [13:0] yp;
  logic               on_screen;

  assign w_clamp = (screen_width > SCREEN_MAX) ? SCREEN_MAX : screen_width;
  assign h_clamp = (screen_height > SCREEN_MAX) ? SCREEN_MAX : screen_height;

  assign ox = div_out.neg_x ? -$signed({2'b00, div_out.quo_x}) : $signed({2'b00, div_out.quo_x});
  assign oy = div_out.neg_y ? -$signed({2'b00, div_out.quo_y}) : $signed({2'b00, div_out.quo_y});

  assign xp = $signed({2'b00, w_clamp[DIM_W-1:1]}) + ox;
  assign yp = $signed({2'b00, h_clamp[DIM_W-1:1]}) - oy;

  assign on_screen = !xp[13] && !yp[13]
                     && (xp < $signed({1'b0, w_clamp}))
                     && (yp < $signed({1'b0, h_clamp}));

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES]) begin
      x_pixel <= on_screen ? xp[PIX_W-1:0] : '0;
      y_pixel <= on_screen ? yp[PIX_W-1:0] : '0;
      shade   <= on_screen ? div_out.shade : '0;
      visible <= on_screen;
    end
  end

  // The input is held off only when every stage is full and the output is stalled.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    point_stall |-> ((&v) && pixel_stall))
    else $error("input stalled while the pipeline has room");

  // An accepted point transaction occupies the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (point_valid && !point_stall) |=> v[ST_ANGLE])
    else $error("accepted point did not enter the pipeline");

  // A blocked divider stage keeps its item.
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (v[DIV_FIRST] && !en[DIV_FIRST]) |=> v[DIV_FIRST])
    else $error("blocked divider stage dropped its item");

  // Points off screen report all fields as zero.
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !visible) |-> (x_pixel == '0 && y_pixel == '0 && shade == '0))
    else $error("hidden point carries nonzero fields");

  // Visible points lie inside the clipped screen.
  a_visible_inside: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && visible) |-> ({1'b0, x_pixel} < w_clamp && {1'b0, y_pixel} < h_clamp))
    else $error("visible point outside the screen");

endmodule

@@ hdl/tpp_angle.sv @@
module tpp_angle
  import tpp_pkg::*;
(
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [15:0] frame,
  input  logic [7:0]  sector,
  input  logic [5:0]  ring,
  input  logic [15:0] ring_spin_rate,
  input  logic [15:0] tube_spin_rate,
  output trig_req_t   req
);

  localparam sector_tbl_t SECTOR_ANGLE = build_sector_angle();
  localparam ring_tbl_t RING_ANGLE = build_ring_angle();

  logic [31:0] alpha_prod;
  logic [31:0] beta_prod;
  logic [15:0] rot_alpha;
  logic [15:0] rot_beta;
  logic [15:0] sector_ang;
  logic [15:0] ring_ang;
  logic [7:0]  shade;
  logic [15:0] alpha;
  logic [15:0] beta;

  assign alpha_prod = 32'(frame) * 32'(ring_spin_rate);
  assign beta_prod  = 32'(frame) * 32'(tube_spin_rate);

  // First stage: spin products and the fixed angle of each index.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rot_alpha  <= alpha_prod[23:8];
      rot_beta   <= beta_prod[23:8];
      sector_ang <= SECTOR_ANGLE[sector];
      ring_ang   <= RING_ANGLE[ring];
      shade      <= 8'(ring) + {sector[5:0], 2'b00};
    end
  end

  assign alpha = sector_ang + rot_alpha;
  assign beta  = ring_ang + rot_beta;

  // Second stage: table addresses for sine and cosine of both angles.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      req.sa    <= sine_addr(alpha[15:4]);
      req.ca    <= sine_addr(alpha[15:4] + 12'd1024);
      req.sb    <= sine_addr(beta[15:4]);
      req.cb    <= sine_addr(beta[15:4] + 12'd1024);
      req.shade <= shade;
    end
  end

endmodule

@@ hdl/tpp_sine_rom.sv @@
module tpp_sine_rom
  import tpp_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [QSINE_AW-1:0] addr_a,
  input  logic [QSINE_AW-1:0] addr_b,
  output logic [MAG_W-1:0]    data_a,
  output logic [MAG_W-1:0]    data_b
);

  localparam qsine_tbl_t QSINE = build_quarter_sine();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= QSINE[addr_a];
      data_b <= QSINE[addr_b];
    end
  end

endmodule

@@ hdl/tpp_scale.sv @@
module tpp_scale
  import tpp_pkg::*;
(
  input  logic               clk,
  input  logic [2:0]         en,
  input  trig_val_t          val,
  input  logic [FOCAL_W-1:0] focal_length,
  output div_in_t            dout
);

  logic [TERM_W-1:0]   cb_term;
  logic [TERM_W-1:0]   sb_term;
  logic [R_W-1:0]      r4;
  logic [Z_W-1:0]      z4;
  logic [MAG_W-1:0]    sa_mag4;
  logic [MAG_W-1:0]    ca_mag4;
  logic                sa_neg4;
  logic                ca_neg4;
  logic [7:0]          shade4;
  logic [PROD_W-1:0]   xmag5;
  logic [PROD_W-1:0]   ymag5;
  logic [Z_W-1:0]      z5;
  logic                sa_neg5;
  logic                ca_neg5;
  logic [7:0]          shade5;
  logic [SCALED_W-1:0] scaled_x;
  logic [SCALED_W-1:0] scaled_y;

  assign cb_term = TERM_W'(val.cb_mag) * TERM_W'(TUBE_RADIUS);
  assign sb_term = TERM_W'(val.sb_mag) * TERM_W'(TUBE_RADIUS);

  // Ring radius and depth; both stay positive for every angle.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      r4      <= val.cb_neg ? R_BASE - R_W'(cb_term) : R_BASE + R_W'(cb_term);
      z4      <= val.sb_neg ? Z_BASE - Z_W'(sb_term) : Z_BASE + Z_W'(sb_term);
      sa_mag4 <= val.sa_mag;
      ca_mag4 <= val.ca_mag;
      sa_neg4 <= val.sa_neg;
      ca_neg4 <= val.ca_neg;
      shade4  <= val.shade;
    end
  end

  // Magnitudes of x and y; the sign comes from the alpha sine and cosine.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      xmag5   <= PROD_W'(r4) * PROD_W'(ca_mag4);
      ymag5   <= PROD_W'(r4) * PROD_W'(sa_mag4);
      z5      <= z4;
      sa_neg5 <= sa_neg4;
      ca_neg5 <= ca_neg4;
      shade5  <= shade4;
    end
  end

  assign scaled_x = SCALED_W'(xmag5) * SCALED_W'(focal_length);
  assign scaled_y = SCALED_W'(ymag5) * SCALED_W'(focal_length);

  // The divisor is z shifted up, so its zero low bits are dropped from the dividend.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      dout.num_x <= scaled_x[SCALED_W-1:DEN_SHIFT];
      dout.num_y <= scaled_y[SCALED_W-1:DEN_SHIFT];
      dout.z     <= z5;
      dout.neg_x <= ca_neg5;
      dout.neg_y <= sa_neg5;
      dout.shade <= shade5;
    end
  end

endmodule

@@ hdl/tpp_divider.sv @@
module tpp_divider
  import tpp_pkg::*;
(
  input  logic             clk,
  input  logic [QUO_W-1:0] en,
  input  div_in_t          din,
  output div_out_t         dout
);

  div_stage_t first;
  div_stage_t cur [0:QUO_W-1];
  div_stage_t nxt [0:QUO_W-1];
  div_stage_t stage_q [0:QUO_W-1];

  always_comb begin
    first       = '0;
    first.rem_x = din.num_x;
    first.rem_y = din.num_y;
    first.z     = din.z;
    first.neg_x = din.neg_x;
    first.neg_y = din.neg_y;
    first.shade = din.shade;
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 0; s < QUO_W; s++) begin : g_step
    localparam int B = QUO_W - 1 - s;

    div_wide_t dvs;
    div_wide_t diff_x;
    div_wide_t diff_y;
    logic      ge_x;
    logic      ge_y;

    if (s == 0) begin : g_first
      assign cur[s] = first;
    end else begin : g_rest
      assign cur[s] = stage_q[s-1];
    end

    assign dvs    = div_wide_t'(cur[s].z) << B;
    assign ge_x   = div_wide_t'(cur[s].rem_x) >= dvs;
    assign ge_y   = div_wide_t'(cur[s].rem_y) >= dvs;
    assign diff_x = div_wide_t'(cur[s].rem_x) - dvs;
    assign diff_y = div_wide_t'(cur[s].rem_y) - dvs;

    always_comb begin
      nxt[s]          = cur[s];
      nxt[s].rem_x    = ge_x ? diff_x[NUM_W-1:0] : cur[s].rem_x;
      nxt[s].rem_y    = ge_y ? diff_y[NUM_W-1:0] : cur[s].rem_y;
      nxt[s].quo_x[B] = ge_x;
      nxt[s].quo_y[B] = ge_y;
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        stage_q[s] <= nxt[s];
      end
    end
  end

  assign dout.quo_x = stage_q[QUO_W-1].quo_x;
  assign dout.quo_y = stage_q[QUO_W-1].quo_y;
  assign dout.neg_x = stage_q[QUO_W-1].neg_x;
  assign dout.neg_y = stage_q[QUO_W-1].neg_y;
  assign dout.shade = stage_q[QUO_W-1].shade;

endmodule
